// ===== hw/rtl/fptr_pkg.sv =====
// Package for the footswitch press-toggle relay controller.
// Holds the register index codes, configuration, state and result types.
// No dependencies; every other RTL file imports it.
`timescale 1ns / 1ps

package fptr_pkg;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTEG_CEILING     = 2'd0,
        CFG_LONG_HOLD_TICKS   = 2'd1,
        CFG_RELAY_PULSE_TICKS = 2'd2,
        CFG_INITIAL_STATE     = 2'd3
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic [7:0]  INTEG_CEILING_RST     = 8'd10;
    localparam logic [15:0] LONG_HOLD_TICKS_RST   = 16'd1000;
    localparam logic [15:0] RELAY_PULSE_TICKS_RST = 16'd20;
    localparam logic        INITIAL_STATE_RST     = 1'b0;

    // Current configuration.
    typedef struct packed {
        logic [7:0]  integ_ceiling;
        logic [15:0] long_hold_ticks;
        logic [15:0] relay_pulse_ticks;
        logic        initial_state;
    } t_cfg;

    // Controller state carried from one word to the next.
    typedef struct packed {
        logic [7:0]  integrator;
        logic [15:0] held_ticks;
        logic        was_released;
        logic        toggle_pending;
        logic        turn_on_pending;
        logic        on_state;
        logic        state_valid;
        logic [16:0] pulse_timer;
    } t_state;

    localparam t_state STATE_RST = '{
        integrator:      8'd0,
        held_ticks:      16'd0,
        was_released:    1'b1,
        toggle_pending:  1'b0,
        turn_on_pending: 1'b0,
        on_state:        1'b0,
        state_valid:     1'b0,
        pulse_timer:     17'd0
    };

    // One result word.
    typedef struct packed {
        logic switch_on;
        logic coil_set;
        logic coil_reset;
        logic partner_off;
        logic save_state;
        logic busy_res;
    } t_result;

endpackage

// ===== hw/rtl/fptr_cfg.sv =====
// Configuration registers of the footswitch relay controller.
// Depends on fptr_pkg for the index codes, reset values and t_cfg.
`timescale 1ns / 1ps

module fptr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fptr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fptr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fptr_pkg::t_cfg                  o_cfg
);
    import fptr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode a write into the addressed register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INTEG_CEILING:     n_cfg.integ_ceiling     = i_cfg_data[7:0];
                CFG_LONG_HOLD_TICKS:   n_cfg.long_hold_ticks   = i_cfg_data;
                CFG_RELAY_PULSE_TICKS: n_cfg.relay_pulse_ticks = i_cfg_data;
                CFG_INITIAL_STATE:     n_cfg.initial_state     = i_cfg_data[0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    // Register bank with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.integ_ceiling     <= INTEG_CEILING_RST;
            r_cfg.long_hold_ticks   <= LONG_HOLD_TICKS_RST;
            r_cfg.relay_pulse_ticks <= RELAY_PULSE_TICKS_RST;
            r_cfg.initial_state     <= INITIAL_STATE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/fptr_step.sv =====
// Per-tick logic of the footswitch relay controller: relay pulse timing,
// startup load, partner force-off and the debounce/press decoding.
// Purely combinational; depends on fptr_pkg.
`timescale 1ns / 1ps

module fptr_step (
    input  fptr_pkg::t_cfg    i_cfg,
    input  fptr_pkg::t_state  i_state,
    input  logic              i_raw_level,
    input  logic              i_force_off,
    output fptr_pkg::t_state  o_state,
    output fptr_pkg::t_result o_result
);
    import fptr_pkg::*;

    logic [15:0] pulse_len;
    logic [16:0] pulse_len_x;
    logic [16:0] pulse_total;
    logic [7:0]  lim;
    logic [15:0] held_inc;
    logic        fire;
    logic        target;
    t_state      st;
    t_result     res;

    // Zero lengths behave as one; the full pulse plus hold is twice that.
    assign pulse_len   = (i_cfg.relay_pulse_ticks == 16'd0) ? 16'd1 : i_cfg.relay_pulse_ticks;
    assign pulse_len_x = {1'b0, pulse_len};
    assign pulse_total = {pulse_len, 1'b0} - 17'd1;
    assign lim         = (i_cfg.integ_ceiling == 8'd0) ? 8'd1 : i_cfg.integ_ceiling;

    always_comb begin
        st       = i_state;
        res      = '0;
        held_inc = 16'd0;
        fire     = 1'b0;
        target   = 1'b0;

        if (i_state.pulse_timer != 17'd0) begin
            // Coil drive during the first half, then hold; save at the turnover.
            if (i_state.pulse_timer > pulse_len_x) begin
                res.coil_set   = i_state.on_state;
                res.coil_reset = !i_state.on_state;
            end
            res.save_state = (i_state.pulse_timer == pulse_len_x);
            res.busy_res   = 1'b1;
            st.pulse_timer = i_state.pulse_timer - 17'd1;
        end else if (!i_state.state_valid) begin
            // First tick after reset loads the saved state and pulses the relay.
            st.state_valid = 1'b1;
            st.on_state    = i_cfg.initial_state;
            st.pulse_timer = pulse_total;
            res.coil_set   = i_cfg.initial_state;
            res.coil_reset = !i_cfg.initial_state;
            res.busy_res   = 1'b1;
        end else if (i_force_off && i_state.on_state) begin
            // Partner asks us off.
            st.on_state    = 1'b0;
            st.pulse_timer = pulse_total;
            res.coil_reset = 1'b1;
            res.busy_res   = 1'b1;
        end else begin
            // Integrator: count down while pressed, up toward the limit while released.
            if (!i_raw_level) begin
                if (st.integrator != 8'd0) begin
                    st.integrator = st.integrator - 8'd1;
                end
            end else if (st.integrator < lim) begin
                st.integrator = st.integrator + 8'd1;
            end

            if (st.integrator == 8'd0) begin
                // Pressed: count held time and detect a long press.
                held_inc = (st.held_ticks != 16'hFFFF) ? st.held_ticks + 16'd1
                                                       : st.held_ticks;
                st.held_ticks = held_inc;
                if (held_inc >= i_cfg.long_hold_ticks) begin
                    st.held_ticks     = i_cfg.long_hold_ticks;
                    res.partner_off   = 1'b1;
                    st.toggle_pending = 1'b0;
                end
                if (st.on_state) begin
                    if (st.was_released) begin
                        st.toggle_pending  = 1'b1;
                        st.turn_on_pending = 1'b0;
                    end
                end else begin
                    st.turn_on_pending = 1'b1;
                    st.toggle_pending  = 1'b1;
                end
                st.was_released = 1'b0;
            end else if (st.integrator >= lim) begin
                // Released: act on a pending toggle.
                fire               = st.toggle_pending;
                target             = st.turn_on_pending;
                st.turn_on_pending = 1'b0;
                st.toggle_pending  = 1'b0;
                st.was_released    = 1'b1;
                st.held_ticks      = 16'd0;
                st.integrator      = lim;
                if (fire && (target != st.on_state)) begin
                    st.on_state    = target;
                    st.pulse_timer = pulse_total;
                    res.coil_set   = target;
                    res.coil_reset = !target;
                    res.busy_res   = 1'b1;
                end
            end
        end

        res.switch_on = st.on_state;
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

// ===== hw/rtl/footswitch_press_toggle_relay_top.sv =====
// Top level of the footswitch press-toggle relay controller.
// Instantiates fptr_cfg and fptr_step; depends on fptr_pkg.
// Each accepted word is one tick: an input register, combinational step logic
// and a result register. While the output is not stalled the block takes one
// word per clock cycle, and it gives one result word per input word; a word
// passes from the input register through the step logic into the result
// register. The rate is set by the combinational step logic, whose state
// is updated as a word moves from the input register to the result
// register. While the output is stalled the block holds two words, then
// drops input ready. Configuration writes take effect on the next cycle.
`timescale 1ns / 1ps

module footswitch_press_toggle_relay_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port.
    input  logic                            i_cfg_we,
    input  logic [fptr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fptr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_raw_level,
    input  logic                            i_force_off,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_switch_on,
    output logic                            o_coil_set,
    output logic                            o_coil_reset,
    output logic                            o_partner_off,
    output logic                            o_save_state,
    output logic                            o_busy_res
);
    import fptr_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_raw_level;
    logic    r_force_off;
    logic    r_out_valid;
    logic    advance;

    fptr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fptr_step u_step (
        .i_cfg       (cfg),
        .i_state     (r_state),
        .i_raw_level (r_raw_level),
        .i_force_off (r_force_off),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // A word moves on when the result register is empty or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_raw_level <= i_raw_level;
            r_force_off <= i_force_off;
        end
    end

    // Controller state advances once per word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_switch_on   = r_result.switch_on;
    assign o_coil_set    = r_result.coil_set;
    assign o_coil_reset  = r_result.coil_reset;
    assign o_partner_off = r_result.partner_off;
    assign o_save_state  = r_result.save_state;
    assign o_busy_res    = r_result.busy_res;

endmodule

// ===== dv/footswitch_press_toggle_relay_top_tb.sv =====
// Self-checking testbench for footswitch_press_toggle_relay_top.
// A scoreboard class predicts every result word from the accepted ticks and checks
// the block's output against it; depends on fptr_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module footswitch_press_toggle_relay_top_tb;

    import fptr_pkg::*;

    localparam int CYCLE_LIMIT    = 400_000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_WORDS    = 70;

    // Predicts the controller tick by tick and checks the result words in order.
    class relay_scoreboard;
        bit [7:0]  deb_lim     = INTEG_CEILING_RST;
        bit [15:0] lp_lim      = LONG_HOLD_TICKS_RST;
        bit [15:0] pulse_ticks = RELAY_PULSE_TICKS_RST;
        bit        init_on     = INITIAL_STATE_RST;

        // Controller state as of the last accepted word.
        bit [7:0]  integ;
        bit [15:0] held;
        bit        released = 1'b1;
        bit        toggle_pend;
        bit        on_pend;
        bit        on_state;
        bit        loaded;
        bit [16:0] relay_timer;

        t_result expected_words[$];
        int      live_words;
        int      n_checked;
        int      n_mismatch;

        function void write_reg(t_cfg_idx idx, bit [15:0] val);
            case (idx)
                CFG_INTEG_CEILING:     deb_lim = val[7:0];
                CFG_LONG_HOLD_TICKS:   lp_lim = val;
                CFG_RELAY_PULSE_TICKS: pulse_ticks = val;
                CFG_INITIAL_STATE:     init_on = val[0];
                default: ;
            endcase
        endfunction

        // A zero pulse length behaves as one tick.
        function bit [16:0] coil_ticks();
            return (pulse_ticks == 16'd0) ? 17'd1 : {1'b0, pulse_ticks};
        endfunction

        // A zero debounce limit behaves as one.
        function int deb_eff();
            return (deb_lim == 8'd0) ? 1 : int'(deb_lim);
        endfunction

        // The current tick is the first coil tick; coil drive is followed by a hold.
        function void begin_coil_drive(inout t_result r);
            relay_timer  = 17'(2 * coil_ticks() - 1);
            r.coil_set   = on_state;
            r.coil_reset = !on_state;
            r.busy_res   = 1'b1;
        endfunction

        function void set_switch(bit target, inout t_result r);
            if (target != on_state) begin
                on_state = target;
                begin_coil_drive(r);
            end
        endfunction

        function void note_word(bit raw, bit frc);
            t_result   r;
            bit [16:0] p;
            bit [7:0]  lim;
            bit        fire;
            bit        target;
            r   = '0;
            p   = coil_ticks();
            lim = 8'(deb_eff());
            if (relay_timer != 17'd0) begin
                // Relay pulse or hold running: inputs are ignored.
                if (relay_timer > p) begin
                    r.coil_set   = on_state;
                    r.coil_reset = !on_state;
                end
                if (relay_timer == p) begin
                    r.save_state = 1'b1;
                end
                r.busy_res  = 1'b1;
                relay_timer = relay_timer - 17'd1;
            end else if (!loaded) begin
                // First live tick after reset applies the saved state.
                loaded   = 1'b1;
                on_state = init_on;
                begin_coil_drive(r);
            end else if (frc && on_state) begin
                set_switch(1'b0, r);
            end else begin
                live_words++;
                // Integrator debounce of the raw level.
                if (!raw) begin
                    if (integ > 8'd0) begin
                        integ--;
                    end
                end else if (integ < lim) begin
                    integ++;
                end
                if (integ == 8'd0) begin
                    if (held < 16'hFFFF) begin
                        held++;
                    end
                    if (held >= lp_lim) begin
                        held          = lp_lim;
                        r.partner_off = 1'b1;
                        toggle_pend   = 1'b0;
                    end
                    if (on_state) begin
                        if (released) begin
                            toggle_pend = 1'b1;
                            on_pend     = 1'b0;
                        end
                    end else begin
                        on_pend     = 1'b1;
                        toggle_pend = 1'b1;
                    end
                    released = 1'b0;
                end else if (integ >= lim) begin
                    fire        = toggle_pend;
                    target      = on_pend;
                    on_pend     = 1'b0;
                    toggle_pend = 1'b0;
                    released    = 1'b1;
                    held        = 16'd0;
                    integ       = lim;
                    if (fire) begin
                        set_switch(target, r);
                    end
                end
            end
            r.switch_on = on_state;
            expected_words.push_back(r);
        endfunction

        function void check_word(t_result got);
            t_result want;
            n_checked++;
            if (expected_words.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("result word %0d arrived with nothing pending: %b",
                             n_checked, got);
                end
                return;
            end
            want = expected_words.pop_front();
            if (got.switch_on != want.switch_on || got.coil_set != want.coil_set ||
                got.coil_reset != want.coil_reset || got.partner_off != want.partner_off ||
                got.save_state != want.save_state || got.busy_res != want.busy_res) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("word %0d mismatch (on set rst partner save busy): exp %b got %b",
                             n_checked, want, got);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_idx;
    logic [15:0]       cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              raw_level;
    logic              force_off;
    logic              out_valid;
    logic              out_ready;
    logic              switch_on;
    logic              coil_set;
    logic              coil_reset;
    logic              partner_off;
    logic              save_state;
    logic              busy_res;

    relay_scoreboard   sb;
    int                src_idle_pct;
    int                sink_stall_pct;
    bit                holdoff_req;
    int                stall_left;
    int                cycle_count;

    footswitch_press_toggle_relay_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_raw_level   (raw_level),
        .i_force_off   (force_off),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_switch_on   (switch_on),
        .o_coil_set    (coil_set),
        .o_coil_reset  (coil_reset),
        .o_partner_off (partner_off),
        .o_save_state  (save_state),
        .o_busy_res    (busy_res)
    );

    // Clock with a 4 ns period.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here when requested.
    always @(negedge clk) begin
        if (holdoff_req) begin
            stall_left  = HOLDOFF_CYCLES;
            holdoff_req = 1'b0;
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
        end
    end

    // Both handshakes are sampled at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.note_word(raw_level, force_off);
            end
            if (out_valid && out_ready) begin
                sb.check_word(t_result'({switch_on, coil_set, coil_reset,
                                         partner_off, save_state, busy_res}));
            end
        end
    end

    // Offers one tick word and returns at the edge that accepts it.
    task automatic send_word(bit raw, bit frc);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        raw_level <= raw;
        force_off <= frc;
        do begin
            @(posedge clk);
        end while (!in_ready);
    endtask

    task automatic pause_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits for every pending result, then lets the pipeline settle.
    task automatic drain_results();
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(int deb, int lp, int pulse, int init);
        write_reg(CFG_INTEG_CEILING, 16'(deb));
        write_reg(CFG_LONG_HOLD_TICKS, 16'(lp));
        write_reg(CFG_RELAY_PULSE_TICKS, 16'(pulse));
        write_reg(CFG_INITIAL_STATE, 16'(init));
    endtask

    // One footswitch gesture: mostly clean presses with bounce, some force-off
    // requests from the partner and some plain noise.
    task automatic play_gesture();
        int kind;
        int n;
        kind = $urandom_range(99, 0);
        if (kind < 70) begin
            repeat ($urandom_range(3, 0)) send_word(1'($urandom_range(1, 0)), 1'b0);
            if ($urandom_range(1, 0) == 1) begin
                n = sb.deb_eff() + int'(sb.lp_lim) + $urandom_range(8, 0);
            end else begin
                n = sb.deb_eff() + $urandom_range(int'(sb.lp_lim), 0);
            end
            repeat (n) send_word(1'b0, $urandom_range(19, 0) == 0);
            repeat ($urandom_range(3, 0)) send_word(1'($urandom_range(1, 0)), 1'b0);
            n = sb.deb_eff() + $urandom_range(4, 0);
            repeat (n) send_word(1'b1, $urandom_range(19, 0) == 0);
        end else if (kind < 85) begin
            repeat ($urandom_range(2, 1)) send_word(1'($urandom_range(1, 0)), 1'b1);
        end else begin
            repeat ($urandom_range(6, 1)) begin
                send_word(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end
        end
    endtask

    // Random phase under a fresh small setting and the given idling.
    task automatic run_phase(int src_pct, int sink_pct, bit with_holdoff);
        int target;
        apply_setting($urandom_range(5, 1), $urandom_range(24, 2), $urandom_range(3, 1),
                      $urandom_range(1, 0));
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        target         = sb.live_words + PHASE_WORDS;
        if (with_holdoff) begin
            // The receiver holds off while the sender keeps offering words.
            holdoff_req = 1'b1;
            repeat (40) send_word(1'($urandom_range(1, 0)), $urandom_range(9, 0) == 0);
            // Sender waits until every result is back before carrying on.
            pause_input();
            drain_results();
        end
        while (sb.live_words < target) begin
            play_gesture();
        end
        pause_input();
        drain_results();
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        raw_level      = 1'b1;
        force_off      = 1'b0;
        out_ready      = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holdoff_req    = 1'b0;
        stall_left     = 0;
        cycle_count    = 0;
        sb             = new;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Start switched on; the other registers keep their reset values.
        write_reg(CFG_INITIAL_STATE, 16'd1);
        repeat (60) send_word($urandom_range(3, 0) != 0, 1'b0);
        pause_input();
        drain_results();

        // Directed ticks with the shortest pulse and debounce limit and a long-press limit of 3.
        apply_setting(1, 3, 1, 0);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        // Short press toggles off at release.
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b0);
        // Force-off while off has no effect; the press turns on at release.
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        // Long press while on asks the partner off and keeps it on.
        repeat (4) send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        // Long press while on keeps it on.
        repeat (4) send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);
        pause_input();
        drain_results();

        // Zero registers: debounce and pulse act as one, every press is long.
        apply_setting(0, 0, 0, 1);
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        pause_input();
        drain_results();

        // Park the switch off and idle so the widest setting starts no pulse.
        do begin
            repeat (4) send_word(1'b1, 1'b1);
            pause_input();
            drain_results();
        end while (sb.on_state || sb.relay_timer != 17'd0);
        apply_setting(255, 65535, 65535, 1);
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        repeat (40) send_word(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
        pause_input();
        drain_results();

        // Random phases across the idling patterns.
        run_phase(0, 0, 1'b0);
        run_phase(74, 0, 1'b0);
        run_phase(0, 74, 1'b0);
        run_phase(36, 36, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (8) @(posedge clk);
        if (sb.n_mismatch == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
